// ----- hw/rtl/e2q_pkg.sv -----
// ----------------------------------------------------------------------------
// e2q_pkg
// Constants, CORDIC arctangent table and Q30 product helper shared by the
// Euler angle to quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int CORDIC_ITERS = 30;
	localparam int CORDIC_X0    = 652032874;   // inverse CORDIC gain in Q30
	localparam int XY_W         = 33;          // Q30 sine/cosine and products
	localparam int Z_W          = 34;          // residual angle, 2^33 per turn
	localparam int LANES        = 3;

	typedef logic signed [XY_W-1:0] xy_t;
	typedef logic signed [Z_W-1:0]  zang_t;

	// arctangent of 2^-i, 2^32 per turn
	localparam logic [31:0] ATAN_TURN32 [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// Q30 x Q30 -> Q30, round half up
	function automatic xy_t mul_q30(input xy_t a, input xy_t b);
		logic signed [2*XY_W-1:0] p;
		p = 66'(a) * 66'(b);
		p = p + (66'sd1 <<< 29);
		return p[XY_W+29:30];
	endfunction

endpackage

// ----- hw/rtl/euler_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Three binary angles in, unit quaternion out in Q1.14 (at default width).
// Half-angle sine/cosine by one pipelined CORDIC per angle, then two
// product stages and a rounding/saturation stage.
// ----------------------------------------------------------------------------
// Channel   | Signals                                           | Transfer
// ----------+---------------------------------------------------+-----------------
// input     | start, busy, heading_/attitude_/bank_angle        | start & !busy
// result    | done, quat_w, quat_x, quat_y, quat_z              | done, one cycle
//
// One transfer may enter every cycle; busy is held low.
// The pipeline has one stage per CORDIC step,
// two multiplier stages and the output stage.
// Reset clears the valid bits only; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
	parameter int ANGLE_WIDTH = 16,
	parameter int QUAT_WIDTH  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [ANGLE_WIDTH-1:0] heading_angle,
	input  logic signed [ANGLE_WIDTH-1:0] attitude_angle,
	input  logic signed [ANGLE_WIDTH-1:0] bank_angle,
	output logic                          done,
	output logic signed [QUAT_WIDTH-1:0]  quat_w,
	output logic signed [QUAT_WIDTH-1:0]  quat_x,
	output logic signed [QUAT_WIDTH-1:0]  quat_y,
	output logic signed [QUAT_WIDTH-1:0]  quat_z
);

	localparam int ITERS = e2q_pkg::CORDIC_ITERS;
	localparam int XY_W  = e2q_pkg::XY_W;
	localparam int Z_W   = e2q_pkg::Z_W;
	localparam int ASH   = 32 - ANGLE_WIDTH;
	localparam int QSH   = 32 - QUAT_WIDTH;
	localparam logic signed [Z_W-1:0] QLIM = Z_W'(64'sd1 <<< (QUAT_WIDTH - 2));

	e2q_pkg::zang_t ang_z [e2q_pkg::LANES];

	logic           vld_s [ITERS];
	e2q_pkg::xy_t   cx_s  [e2q_pkg::LANES][ITERS];
	e2q_pkg::xy_t   cy_s  [e2q_pkg::LANES][ITERS];
	e2q_pkg::zang_t cz_s  [e2q_pkg::LANES][ITERS];

	logic         vld_s31;
	e2q_pkg::xy_t c1c2_s31, s1s2_s31, s1c2_s31, c1s2_s31, c3_s31, s3_s31;

	logic         vld_s32;
	e2q_pkg::xy_t prd_s32 [8];

	logic                         vld_s33;
	logic signed [QUAT_WIDTH-1:0] quat_s33 [4];

	assign busy = 1'b0;

	assign ang_z[0] = Z_W'(heading_angle)  <<< ASH;
	assign ang_z[1] = Z_W'(attitude_angle) <<< ASH;
	assign ang_z[2] = Z_W'(bank_angle)     <<< ASH;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ITERS; k++) vld_s[k] <= 1'b0;
			vld_s31 <= 1'b0;
			vld_s32 <= 1'b0;
			vld_s33 <= 1'b0;
		end else begin
			vld_s[0] <= start;
			for (int k = 1; k < ITERS; k++) vld_s[k] <= vld_s[k-1];
			vld_s31 <= vld_s[ITERS-1];
			vld_s32 <= vld_s31;
			vld_s33 <= vld_s32;
		end
	end

	// CORDIC rotation, one step per stage
	for (genvar l = 0; l < e2q_pkg::LANES; l++) begin : g_lane
		for (genvar k = 0; k < ITERS; k++) begin : g_step
			e2q_pkg::xy_t   xi, yi;
			e2q_pkg::zang_t zi, da;
			if (k == 0) begin : g_first
				assign xi = XY_W'(e2q_pkg::CORDIC_X0);
				assign yi = '0;
				assign zi = ang_z[l];
			end else begin : g_next
				assign xi = cx_s[l][k-1];
				assign yi = cy_s[l][k-1];
				assign zi = cz_s[l][k-1];
			end
			assign da = Z_W'({e2q_pkg::ATAN_TURN32[k], 1'b0});
			always_ff @(posedge clk) begin
				if (!zi[Z_W-1]) begin
					cx_s[l][k] <= xi - (yi >>> k);
					cy_s[l][k] <= yi + (xi >>> k);
					cz_s[l][k] <= zi - da;
				end else begin
					cx_s[l][k] <= xi + (yi >>> k);
					cy_s[l][k] <= yi - (xi >>> k);
					cz_s[l][k] <= zi + da;
				end
			end
		end
	end

	// pair products
	always_ff @(posedge clk) begin
		c1c2_s31 <= e2q_pkg::mul_q30(cx_s[0][ITERS-1], cx_s[1][ITERS-1]);
		s1s2_s31 <= e2q_pkg::mul_q30(cy_s[0][ITERS-1], cy_s[1][ITERS-1]);
		s1c2_s31 <= e2q_pkg::mul_q30(cy_s[0][ITERS-1], cx_s[1][ITERS-1]);
		c1s2_s31 <= e2q_pkg::mul_q30(cx_s[0][ITERS-1], cy_s[1][ITERS-1]);
		c3_s31   <= cx_s[2][ITERS-1];
		s3_s31   <= cy_s[2][ITERS-1];
	end

	// triple products
	always_ff @(posedge clk) begin
		prd_s32[0] <= e2q_pkg::mul_q30(c1c2_s31, c3_s31);
		prd_s32[1] <= e2q_pkg::mul_q30(s1s2_s31, s3_s31);
		prd_s32[2] <= e2q_pkg::mul_q30(c1c2_s31, s3_s31);
		prd_s32[3] <= e2q_pkg::mul_q30(s1s2_s31, c3_s31);
		prd_s32[4] <= e2q_pkg::mul_q30(s1c2_s31, c3_s31);
		prd_s32[5] <= e2q_pkg::mul_q30(c1s2_s31, s3_s31);
		prd_s32[6] <= e2q_pkg::mul_q30(c1s2_s31, c3_s31);
		prd_s32[7] <= e2q_pkg::mul_q30(s1c2_s31, s3_s31);
	end

	// sums, rounding to output precision, saturation
	for (genvar q = 0; q < 4; q++) begin : g_out
		logic signed [Z_W-1:0] sum, rnd, sat;
		if (q == 0 || q == 3) begin : g_diff
			assign sum = Z_W'(prd_s32[2*q]) - Z_W'(prd_s32[2*q+1]);
		end else begin : g_add
			assign sum = Z_W'(prd_s32[2*q]) + Z_W'(prd_s32[2*q+1]);
		end
		if (QSH > 0) begin : g_rnd
			assign rnd = (sum + Z_W'(64'sd1 <<< (QSH - 1))) >>> QSH;
		end else begin : g_exact
			assign rnd = sum;
		end
		always_comb begin
			if (rnd > QLIM)
				sat = QLIM;
			else if (rnd < -QLIM)
				sat = -QLIM;
			else
				sat = rnd;
		end
		always_ff @(posedge clk) begin
			quat_s33[q] <= sat[QUAT_WIDTH-1:0];
		end
	end

	assign done   = vld_s33;
	assign quat_w = quat_s33[0];
	assign quat_x = quat_s33[1];
	assign quat_y = quat_s33[2];
	assign quat_z = quat_s33[3];

endmodule
